// ===== src/lhsfp_pkg.sv =====
// Shared types, constants and the character map of the scanner frame parser.
// No dependencies; used by the parser, the top level and the testbench.
`timescale 1ns / 1ps

package lhsfp_pkg;

  // framing characters and the data frame marker word
  localparam logic [7:0]  STX_CHAR  = 8'h02;
  localparam logic [7:0]  ETX_CHAR  = 8'h03;
  localparam logic [15:0] MARK_WORD = 16'hFFFF;

  // splice sequence positions held in the skip counter
  localparam logic [3:0] SKIP_IDLE     = 4'd0;
  localparam logic [3:0] SKIP_START    = 4'd1;
  localparam logic [3:0] SKIP_LAST_DROP = 4'd9;
  localparam logic [3:0] SKIP_LEN_FIRST = 4'd10;
  localparam logic [3:0] SKIP_LEN      = 4'd11;
  localparam logic [3:0] SKIP_FCOUNT   = 4'd12;
  localparam logic [3:0] SKIP_DONE     = 4'd13;

  // one result item: one measured point
  typedef struct packed {
    logic [15:0] scan_number;
    logic [15:0] sector_number;
    logic [15:0] distance;
    logic [15:0] angle;
    logic [15:0] start_time;
    logic [15:0] echo;
    logic        last_of_scan;
  } point_t;

  // character to digit value, full 16 bits so odd characters spill upwards
  function automatic logic [15:0] char_value(input logic [7:0] c);
    logic [15:0] cw;
    cw = {8'h00, c};
    if (c < 8'h40) begin
      char_value = cw - 16'h0030;
    end else if (c < 8'h47) begin
      char_value = cw - 16'h0037;
    end else begin
      char_value = cw - 16'h0057;
    end
  endfunction

endpackage

// ===== src/lhsfp_ifs.sv =====
// Valid/ready channel interfaces: received bytes in, parsed points out.
// No dependencies; these interfaces use nothing from lhsfp_pkg.
`timescale 1ns / 1ps

interface lhsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lhsfp_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] scan_number;
  logic [15:0] sector_number;
  logic [15:0] distance;
  logic [15:0] angle;
  logic [15:0] start_time;
  logic [15:0] echo;
  logic        last_of_scan;

  modport source (output valid, output scan_number, output sector_number,
                  output distance, output angle, output start_time,
                  output echo, output last_of_scan, input ready);
  modport sink   (input valid, input scan_number, input sector_number,
                  input distance, input angle, input start_time,
                  input echo, input last_of_scan, output ready);
endinterface

// ===== src/lhsfp_parser.sv =====
// Frame parser state machine: hex word assembly, frame splicing, point build.
// Depends on lhsfp_pkg for the point type, framing constants and char map.
`timescale 1ns / 1ps

module lhsfp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 echo_en,
  output logic                 res_valid,
  output lhsfp_pkg::point_t    res
);

  typedef enum logic [4:0] {
    PH_HUNT, PH_H_ID, PH_H_LEN, PH_H_MARK, PH_SKIP_ETX, PH_T_ETX,
    PH_D_FRAMES, PH_D_NAME, PH_D_PFORMAT, PH_D_PINFO, PH_D_PSENT,
    PH_D_PCOUNT, PH_D_LAYER, PH_S_NUM, PH_S_STEP, PH_S_POINTS,
    PH_S_TSTART, PH_S_DIR, PH_P_DIST, PH_P_ECHO, PH_S_TEND, PH_S_ENDDIR,
    PH_T_STAT, PH_T_STAI, PH_T_CRC
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  nib_r, nib_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [3:0]  skip_r, skip_nxt;
  logic [3:0]  total_r, total_nxt;
  logic [15:0] sector_r, sector_nxt;
  logic [7:0]  astep_r, astep_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] stime_r, stime_nxt;
  logic [15:0] dir_r, dir_nxt;
  logic [15:0] scan_r, scan_nxt;
  logic [15:0] held_r, held_nxt;

  logic [15:0] acc_fed;
  logic        word_done;
  logic [1:0]  nib_fed;
  logic        is_data;
  logic        splice_hit;
  logic        last_sector;
  logic        take_word;
  logic        emit;
  logic [15:0] emit_dist;
  logic [15:0] emit_echo;
  logic [15:0] wc_inc;

  // nibble assembly of the incoming character
  assign acc_fed   = {acc_r[11:0], 4'h0} + lhsfp_pkg::char_value(rx_byte);
  assign word_done = (nib_r == 2'd3);
  assign nib_fed   = word_done ? 2'd0 : nib_r + 2'd1;
  assign wc_inc    = wc_r + 16'd1;

  // counted words run from the frame count word to the sector end direction
  assign is_data     = (phase_r >= PH_D_FRAMES) && (phase_r <= PH_S_ENDDIR);
  assign splice_hit  = ({1'b0, wc_r} + 17'd1) == {1'b0, len_r};
  assign last_sector = ({1'b0, sector_r} + 17'd1) >= {13'd0, total_r};

  // next state for one byte
  always_comb begin
    phase_nxt  = phase_r;
    nib_nxt    = nib_r;
    acc_nxt    = acc_r;
    wc_nxt     = wc_r;
    len_nxt    = len_r;
    skip_nxt   = skip_r;
    total_nxt  = total_r;
    sector_nxt = sector_r;
    astep_nxt  = astep_r;
    left_nxt   = left_r;
    stime_nxt  = stime_r;
    dir_nxt    = dir_r;
    scan_nxt   = scan_r;
    held_nxt   = held_r;
    take_word  = 1'b0;
    emit       = 1'b0;
    emit_dist  = acc_fed;
    emit_echo  = 16'd0;

    // framing phases outside words
    unique case (phase_r)
      PH_SKIP_ETX: begin
        if (rx_byte == lhsfp_pkg::ETX_CHAR) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_T_ETX: begin
        phase_nxt = PH_HUNT;
      end
      PH_H_ID, PH_H_LEN, PH_H_MARK: begin
        take_word = 1'b1;
      end
      PH_D_FRAMES, PH_D_NAME, PH_D_PFORMAT, PH_D_PINFO, PH_D_PSENT,
      PH_D_PCOUNT, PH_D_LAYER, PH_S_NUM, PH_S_STEP, PH_S_POINTS,
      PH_S_TSTART, PH_S_DIR, PH_P_DIST, PH_P_ECHO, PH_S_TEND, PH_S_ENDDIR,
      PH_T_STAT, PH_T_STAI, PH_T_CRC: begin
        // continuation frame splice ahead of the next word
        priority if (skip_r == lhsfp_pkg::SKIP_IDLE && nib_r == 2'd0 && splice_hit) begin
          skip_nxt = lhsfp_pkg::SKIP_START;
        end else if (skip_r >= lhsfp_pkg::SKIP_START &&
                     skip_r <= lhsfp_pkg::SKIP_LAST_DROP) begin
          skip_nxt = skip_r + 4'd1;
        end else if (skip_r >= lhsfp_pkg::SKIP_LEN_FIRST &&
                     skip_r <= lhsfp_pkg::SKIP_FCOUNT) begin
          acc_nxt  = acc_fed;
          nib_nxt  = nib_fed;
          skip_nxt = (skip_r == lhsfp_pkg::SKIP_LEN_FIRST) ? lhsfp_pkg::SKIP_LEN : skip_r;
          if (word_done) begin
            acc_nxt = 16'd0;
            if (skip_r == lhsfp_pkg::SKIP_FCOUNT) begin
              wc_nxt   = 16'd1;
              skip_nxt = lhsfp_pkg::SKIP_DONE;
            end else begin
              len_nxt  = acc_fed;
              skip_nxt = lhsfp_pkg::SKIP_FCOUNT;
            end
          end
        end else begin
          skip_nxt  = lhsfp_pkg::SKIP_IDLE;
          take_word = 1'b1;
        end
      end
      default: begin
        // hunting for the start byte, also any stray phase code
        phase_nxt = PH_HUNT;
        if (rx_byte == lhsfp_pkg::STX_CHAR) begin
          phase_nxt = PH_H_ID;
          nib_nxt   = 2'd0;
          acc_nxt   = 16'd0;
          skip_nxt  = lhsfp_pkg::SKIP_IDLE;
        end
      end
    endcase

    // word level parsing
    if (take_word) begin
      acc_nxt = acc_fed;
      nib_nxt = nib_fed;
      if (word_done) begin
        acc_nxt = 16'd0;
        if (is_data) begin
          wc_nxt = wc_inc;
        end
        unique case (phase_r)
          PH_H_ID:  phase_nxt = PH_H_LEN;
          PH_H_LEN: begin
            len_nxt   = acc_fed;
            phase_nxt = PH_H_MARK;
          end
          PH_H_MARK: begin
            if (acc_fed == lhsfp_pkg::MARK_WORD) begin
              scan_nxt  = scan_r + 16'd1;
              wc_nxt    = 16'd1;
              skip_nxt  = lhsfp_pkg::SKIP_IDLE;
              phase_nxt = PH_D_FRAMES;
            end else begin
              phase_nxt = PH_SKIP_ETX;
            end
          end
          PH_D_FRAMES:  phase_nxt = PH_D_NAME;
          PH_D_NAME:    phase_nxt = PH_D_PFORMAT;
          PH_D_PFORMAT: phase_nxt = PH_D_PINFO;
          PH_D_PINFO: begin
            total_nxt = acc_fed[3:0];
            phase_nxt = PH_D_PSENT;
          end
          PH_D_PSENT:  phase_nxt = PH_D_PCOUNT;
          PH_D_PCOUNT: phase_nxt = PH_D_LAYER;
          PH_D_LAYER:  phase_nxt = PH_S_NUM;
          PH_S_NUM: begin
            sector_nxt = acc_fed;
            phase_nxt  = PH_S_STEP;
          end
          PH_S_STEP: begin
            astep_nxt = acc_fed[7:0];
            phase_nxt = PH_S_POINTS;
          end
          PH_S_POINTS: begin
            left_nxt  = acc_fed;
            phase_nxt = PH_S_TSTART;
          end
          PH_S_TSTART: begin
            stime_nxt = acc_fed;
            phase_nxt = PH_S_DIR;
          end
          PH_S_DIR: begin
            dir_nxt   = acc_fed;
            phase_nxt = (left_r != 16'd0) ? PH_P_DIST : PH_S_TEND;
          end
          PH_P_DIST: begin
            if (echo_en) begin
              held_nxt  = acc_fed;
              phase_nxt = PH_P_ECHO;
            end else begin
              emit = 1'b1;
            end
          end
          PH_P_ECHO: begin
            emit      = 1'b1;
            emit_dist = held_r;
            emit_echo = acc_fed;
          end
          PH_S_TEND:   phase_nxt = PH_S_ENDDIR;
          PH_S_ENDDIR: phase_nxt = last_sector ? PH_T_STAT : PH_S_NUM;
          PH_T_STAT:   phase_nxt = PH_T_STAI;
          PH_T_STAI:   phase_nxt = PH_T_CRC;
          PH_T_CRC:    phase_nxt = PH_T_ETX;
          default:     phase_nxt = PH_HUNT;
        endcase
      end
    end

    // point bookkeeping
    if (emit) begin
      left_nxt  = left_r - 16'd1;
      dir_nxt   = dir_r + {8'd0, astep_r};
      phase_nxt = (left_r != 16'd1) ? PH_P_DIST : PH_S_TEND;
    end
  end

  // result of this byte
  assign res_valid         = step && emit;
  assign res.scan_number   = scan_r;
  assign res.sector_number = sector_r;
  assign res.distance      = emit_dist;
  assign res.angle         = dir_r;
  assign res.start_time    = stime_r;
  assign res.echo          = emit_echo;
  assign res.last_of_scan  = (left_r == 16'd1) && last_sector;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      nib_r    <= 2'd0;
      acc_r    <= 16'd0;
      wc_r     <= 16'd0;
      len_r    <= 16'd0;
      skip_r   <= lhsfp_pkg::SKIP_IDLE;
      total_r  <= 4'd0;
      sector_r <= 16'd0;
      astep_r  <= 8'd0;
      left_r   <= 16'd0;
      stime_r  <= 16'd0;
      dir_r    <= 16'd0;
      scan_r   <= 16'd0;
      held_r   <= 16'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      nib_r    <= nib_nxt;
      acc_r    <= acc_nxt;
      wc_r     <= wc_nxt;
      len_r    <= len_nxt;
      skip_r   <= skip_nxt;
      total_r  <= total_nxt;
      sector_r <= sector_nxt;
      astep_r  <= astep_nxt;
      left_r   <= left_nxt;
      stime_r  <= stime_nxt;
      dir_r    <= dir_nxt;
      scan_r   <= scan_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

// ===== src/lidar_hex_scan_frame_parser_core.sv =====
// Top level of the scanner frame parser: byte input stage, parser, point output stage.
// Depends on lhsfp_pkg, lhsfp_ifs (channel interfaces) and lhsfp_parser.
`timescale 1ns / 1ps

// Usage
//   in_byte   : one received character per item (rx_byte), valid/ready.
//   out_point : one parsed point per item, valid/ready; a byte gives zero
//               or one point.
//   cfg_we/cfg_wdata : echo enable register, write only while idle.
// Timing
//   A byte accepted into the input register is parsed there; its point is
//   loaded into the output register when the output stage is free, and a
//   held output stalls the parse of the waiting byte.
//   One byte per cycle is sustained while out_point is not held; the whole
//   parse of a byte is one pass of parser logic between input and output registers.
// Reset
//   rst_n synchronous, active low: parser hunts for a start byte, all
//   counters and the echo enable are cleared, both stages empty.
// Stall
//   While a point waits at the output, one more byte is taken into the
//   input register; after that in_byte.ready drops until the point leaves.
//   Nothing is dropped or repeated.

module lidar_hex_scan_frame_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  lhsfp_byte_if.sink           in_byte,
  lhsfp_point_if.source        out_point,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  logic               echo_r;
  logic               in_valid_r;
  logic [7:0]         byte_r;
  logic               out_valid_r;
  lhsfp_pkg::point_t  point_r;
  logic               out_free;
  logic               step;
  logic               res_valid;
  lhsfp_pkg::point_t  res;

  assign out_free      = !out_valid_r || out_point.ready;
  assign step          = in_valid_r && out_free;
  assign in_byte.ready = !in_valid_r || out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b0;
    end else if (cfg_we) begin
      echo_r <= cfg_wdata;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_byte.ready) begin
      in_valid_r <= in_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      byte_r <= in_byte.rx_byte;
    end
  end

  lhsfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_r),
    .echo_en   (echo_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      point_r <= res;
    end
  end

  assign out_point.valid         = out_valid_r;
  assign out_point.scan_number   = point_r.scan_number;
  assign out_point.sector_number = point_r.sector_number;
  assign out_point.distance      = point_r.distance;
  assign out_point.angle         = point_r.angle;
  assign out_point.start_time    = point_r.start_time;
  assign out_point.echo          = point_r.echo;
  assign out_point.last_of_scan  = point_r.last_of_scan;

endmodule

// ===== tb/tb.sv =====
// Testbench for lidar_hex_scan_frame_parser_core: random and directed scanner frames.
// Depends on lhsfp_pkg, the channel interfaces in lhsfp_ifs and the parser RTL;
// a built-in frame parser predicts every point, checked field by field.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int BYTES_PER_PHASE = 130;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 6;

  // parse position of the predictor, in stream order
  typedef enum logic [4:0] {
    P_HUNT, P_ID, P_LEN, P_MARK, P_SKIP, P_ETX,
    P_FRAMES, P_NAME, P_PFORMAT, P_PINFO, P_PSENT, P_PCOUNT, P_LAYER,
    P_SNUM, P_SSTEP, P_SPOINTS, P_STSTART, P_SDIR, P_DIST, P_ECHO,
    P_STEND, P_SENDDIR, P_TSTAT, P_TSTAI, P_TCRC
  } parse_st_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  lhsfp_byte_if  in_byte ();
  lhsfp_point_if out_point ();

  lidar_hex_scan_frame_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_byte),
    .out_point (out_point),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // byte stream waiting for the driver and points waiting for the monitor
  logic [7:0]        pending_bytes[$];
  logic [7:0]        frame_buf[$];
  lhsfp_pkg::point_t exp_points[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  logic hold_on     = 1'b0;

  int cycle_count    = 0;
  int mismatches     = 0;
  int points_checked = 0;
  int bytes_sent     = 0;
  int phase_bytes    = 0;
  int gen_frames     = 0;
  int gen_splices    = 0;
  int nib_bad_pct    = 1;

  // predictor state
  logic        echo_on;
  parse_st_t   pstate;
  logic [1:0]  nib_cnt;
  logic [15:0] acc;
  logic [15:0] wcnt;
  logic [15:0] flen;
  logic [3:0]  skp;
  logic [3:0]  nsect;
  logic [15:0] cur_sec;
  logic [7:0]  step;
  logic [15:0] pts_left;
  logic [15:0] s_time;
  logic [15:0] dir;
  logic [15:0] scans;
  logic [15:0] held_dist;

  // generator's own view of the word count, to place continuation splices
  logic [15:0] gen_wc;
  logic [15:0] gen_len;

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] hex_val(input logic [7:0] c);
    logic [15:0] cw;
    cw = {8'h00, c};
    if (c < 8'h40) return cw - 16'h0030;
    if (c < 8'h47) return cw - 16'h0037;
    return cw - 16'h0057;
  endfunction

  // shift one character in, true when four have been taken
  function automatic logic feed_char(input logic [7:0] c);
    acc = {acc[11:0], 4'h0} + hex_val(c);
    if (nib_cnt == 2'd3) begin
      nib_cnt = 2'd0;
      return 1'b1;
    end
    nib_cnt = nib_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic logic last_sector();
    return ({1'b0, cur_sec} + 17'd1) >= {13'd0, nsect};
  endfunction

  function automatic void emit_point(input logic [15:0] d, input logic [15:0] e);
    lhsfp_pkg::point_t pt;
    pt.scan_number   = scans;
    pt.sector_number = cur_sec;
    pt.distance      = d;
    pt.angle         = dir;
    pt.start_time    = s_time;
    pt.echo          = e;
    pt.last_of_scan  = (pts_left == 16'd1) && last_sector();
    exp_points.push_back(pt);
    pts_left = pts_left - 16'd1;
    dir      = dir + {8'h00, step};
    pstate   = (pts_left != 16'd0) ? P_DIST : P_STEND;
  endfunction

  function automatic void predict_reset();
    pstate    = P_HUNT;
    nib_cnt   = 2'd0;
    acc       = '0;
    wcnt      = '0;
    flen      = '0;
    skp       = lhsfp_pkg::SKIP_IDLE;
    nsect     = '0;
    cur_sec   = '0;
    step      = '0;
    pts_left  = '0;
    s_time    = '0;
    dir       = '0;
    scans     = '0;
    held_dist = '0;
    echo_on   = 1'b0;
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    logic [15:0] w;
    parse_st_t   ph;
    ph = pstate;
    // framing outside words
    if (ph == P_HUNT) begin
      if (c == lhsfp_pkg::STX_CHAR) begin
        pstate  = P_ID;
        nib_cnt = 2'd0;
        acc     = '0;
        skp     = lhsfp_pkg::SKIP_IDLE;
      end
      return;
    end
    if (ph == P_SKIP) begin
      if (c == lhsfp_pkg::ETX_CHAR) pstate = P_HUNT;
      return;
    end
    if (ph == P_ETX) begin
      pstate = P_HUNT;
      return;
    end
    // continuation splice ahead of a data word
    if (ph >= P_FRAMES) begin
      if (skp == lhsfp_pkg::SKIP_IDLE && nib_cnt == 2'd0 &&
          ({1'b0, wcnt} + 17'd1) == {1'b0, flen}) begin
        skp = lhsfp_pkg::SKIP_START;
        return;
      end
      if (skp >= lhsfp_pkg::SKIP_START && skp <= lhsfp_pkg::SKIP_LAST_DROP) begin
        skp = skp + 4'd1;
        return;
      end
      if (skp >= lhsfp_pkg::SKIP_LEN_FIRST && skp <= lhsfp_pkg::SKIP_FCOUNT) begin
        if (skp == lhsfp_pkg::SKIP_LEN_FIRST) skp = lhsfp_pkg::SKIP_LEN;
        if (feed_char(c)) begin
          if (skp == lhsfp_pkg::SKIP_LEN) begin
            flen = acc;
            skp  = lhsfp_pkg::SKIP_FCOUNT;
          end else begin
            wcnt = 16'd1;
            skp  = lhsfp_pkg::SKIP_DONE;
          end
          acc = '0;
        end
        return;
      end
      skp = lhsfp_pkg::SKIP_IDLE;
    end
    if (!feed_char(c)) return;
    w   = acc;
    acc = '0;
    // one complete word
    case (ph)
      P_ID: pstate = P_LEN;
      P_LEN: begin
        flen   = w;
        pstate = P_MARK;
      end
      P_MARK: begin
        if (w == lhsfp_pkg::MARK_WORD) begin
          scans  = scans + 16'd1;
          wcnt   = 16'd1;
          skp    = lhsfp_pkg::SKIP_IDLE;
          pstate = P_FRAMES;
        end else begin
          pstate = P_SKIP;
        end
      end
      P_FRAMES, P_NAME, P_PFORMAT, P_PINFO, P_PSENT, P_PCOUNT, P_LAYER,
      P_SNUM, P_SSTEP, P_SPOINTS, P_STSTART, P_SDIR, P_STEND, P_SENDDIR: begin
        wcnt = wcnt + 16'd1;
        case (ph)
          P_FRAMES:  pstate = P_NAME;
          P_NAME:    pstate = P_PFORMAT;
          P_PFORMAT: pstate = P_PINFO;
          P_PINFO: begin
            nsect  = w[3:0];
            pstate = P_PSENT;
          end
          P_PSENT:   pstate = P_PCOUNT;
          P_PCOUNT:  pstate = P_LAYER;
          P_LAYER:   pstate = P_SNUM;
          P_SNUM: begin
            cur_sec = w;
            pstate  = P_SSTEP;
          end
          P_SSTEP: begin
            step   = w[7:0];
            pstate = P_SPOINTS;
          end
          P_SPOINTS: begin
            pts_left = w;
            pstate   = P_STSTART;
          end
          P_STSTART: begin
            s_time = w;
            pstate = P_SDIR;
          end
          P_SDIR: begin
            dir    = w;
            pstate = (pts_left != 16'd0) ? P_DIST : P_STEND;
          end
          P_STEND:   pstate = P_SENDDIR;
          default:   pstate = last_sector() ? P_TSTAT : P_SNUM;
        endcase
      end
      P_DIST: begin
        wcnt = wcnt + 16'd1;
        if (echo_on) begin
          held_dist = w;
          pstate    = P_ECHO;
        end else begin
          emit_point(w, 16'h0000);
        end
      end
      P_ECHO: begin
        wcnt = wcnt + 16'd1;
        emit_point(held_dist, w);
      end
      P_TSTAT: pstate = P_TSTAI;
      P_TSTAI: pstate = P_TCRC;
      P_TCRC:  pstate = P_ETX;
      default: pstate = P_HUNT;
    endcase
  endfunction

  // ---------------------------------------------------------------- stream builder

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    if ($urandom_range(1) != 0) return 8'h57 + {4'h0, n};
    return 8'h37 + {4'h0, n};
  endfunction

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 16'd0;
    if (r < 35) return 16'd2;
    if (r < 80) return 16'($urandom_range(3, 40));
    return 16'($urandom);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    frame_buf.push_back(b);
  endtask

  // four hex characters, most significant first, now and then an odd character
  task automatic put_word(input logic [15:0] w);
    logic [7:0] c;
    for (int k = 3; k >= 0; k--) begin
      c = hex_char(w[4*k +: 4]);
      if ($urandom_range(99) < nib_bad_pct) c = 8'($urandom_range(255));
      put_byte(c);
    end
  endtask

  // data word with a continuation splice first when the count calls for one
  task automatic put_fw(input logic [15:0] w, input bit counted);
    if (({1'b0, gen_wc} + 17'd1) == {1'b0, gen_len}) begin
      repeat (4) put_byte(hex_char(4'($urandom_range(15))));
      put_byte(lhsfp_pkg::ETX_CHAR);
      put_byte(lhsfp_pkg::STX_CHAR);
      repeat (4) put_byte(8'($urandom_range(255)));
      gen_len = pick_len();
      put_word(gen_len);
      put_word(16'($urandom));
      gen_wc = 16'd1;
      gen_splices++;
    end
    put_word(w);
    if (counted) gen_wc = gen_wc + 16'd1;
  endtask

  task automatic put_header(input logic [15:0] len);
    put_byte(lhsfp_pkg::STX_CHAR);
    put_word(16'($urandom));
    put_word(len);
    put_word(lhsfp_pkg::MARK_WORD);
    gen_len = len;
    gen_wc  = 16'd1;
    gen_frames++;
  endtask

  task automatic put_sector(input logic [15:0] num, input logic [15:0] stp,
                            input int npts, input logic [15:0] start_dir);
    int r;
    put_fw(num, 1'b1);
    put_fw(stp, 1'b1);
    put_fw(16'(npts), 1'b1);
    put_fw(16'($urandom), 1'b1);
    put_fw(start_dir, 1'b1);
    for (int i = 0; i < npts; i++) begin
      r = $urandom_range(99);
      put_fw((r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom), 1'b1);
      if (echo_on) put_fw((r < 30) ? 16'hFFFF : 16'($urandom), 1'b1);
    end
    put_fw(16'($urandom), 1'b1);
    put_fw(16'($urandom), 1'b1);
  endtask

  task automatic put_trailer();
    put_fw(16'($urandom), 1'b0);
    put_fw(16'($urandom), 1'b0);
    put_fw(16'($urandom), 1'b0);
    put_byte(($urandom_range(99) < 90) ? lhsfp_pkg::ETX_CHAR : 8'($urandom_range(255)));
  endtask

  task automatic put_random_frame();
    int          nsec;
    int          loops;
    int          npts;
    logic [15:0] info;
    logic [15:0] sdir;
    nsec    = ($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 15);
    info    = 16'($urandom);
    info[3:0] = 4'(nsec);
    put_header(pick_len());
    repeat (3) put_fw(16'($urandom), 1'b1);
    put_fw(info, 1'b1);
    repeat (3) put_fw(16'($urandom), 1'b1);
    loops = (nsec == 0) ? 1 : nsec;
    for (int s = 0; s < loops; s++) begin
      if (loops > 3) npts = $urandom_range(0, 2);
      else npts = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 8);
      sdir = ($urandom_range(99) < 20) ? {8'hFF, 8'($urandom)} : 16'($urandom);
      put_sector(16'(s), 16'($urandom), npts, sdir);
    end
    put_trailer();
  endtask

  // frame whose marker word is not the data marker, skipped up to the end byte
  task automatic put_skip_frame();
    logic [15:0] mk;
    mk = 16'($urandom);
    if (mk == lhsfp_pkg::MARK_WORD) mk = 16'hFFFE;
    put_byte(lhsfp_pkg::STX_CHAR);
    put_word(16'($urandom));
    put_word(16'($urandom));
    put_word(mk);
    repeat ($urandom_range(0, 12)) begin
      put_byte(($urandom_range(99) < 15) ? lhsfp_pkg::STX_CHAR
                                         : hex_char(4'($urandom_range(15))));
    end
    put_byte(lhsfp_pkg::ETX_CHAR);
  endtask

  // hand the built frame to the driver, cut short when asked
  task automatic flush_frame(input bit cut);
    int n;
    n = frame_buf.size();
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) pending_bytes.push_back(frame_buf[i]);
    phase_bytes += n;
    frame_buf.delete();
  endtask

  task automatic put_noise();
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(255));
      if (b == lhsfp_pkg::STX_CHAR) b = 8'h55;
      put_byte(b);
    end
    flush_frame(1'b0);
  endtask

  // ---------------------------------------------------------------- control

  task automatic wait_quiet();
    while (pending_bytes.size() != 0 || exp_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_echo(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    echo_on = v;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] point %0d: %s", $realtime, points_checked, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // item driver: holds valid until taken, predicts each accepted byte
  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_byte.valid   <= 1'b0;
      in_byte.rx_byte <= 8'h00;
    end else begin
      if (in_byte.valid && in_byte.ready) begin
        predict_byte(in_byte.rx_byte);
        void'(pending_bytes.pop_front());
        bytes_sent++;
      end
      if (in_byte.valid && !in_byte.ready) begin
        in_byte.valid <= 1'b1;
      end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_byte.valid   <= 1'b1;
        in_byte.rx_byte <= pending_bytes[0];
      end else begin
        in_byte.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin : point_ready
    if (!rst_n) begin
      out_point.ready <= 1'b0;
    end else begin
      out_point.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // point monitor: compare with the oldest expected point
  always @(posedge clk) begin : point_monitor
    lhsfp_pkg::point_t want;
    if (rst_n && out_point.valid && out_point.ready) begin
      if (exp_points.size() == 0) begin
        report_mismatch("point arrived with none expected");
      end else begin
        want = exp_points.pop_front();
        check_field("scan_number", out_point.scan_number, want.scan_number);
        check_field("sector_number", out_point.sector_number, want.sector_number);
        check_field("distance", out_point.distance, want.distance);
        check_field("angle", out_point.angle, want.angle);
        check_field("start_time", out_point.start_time, want.start_time);
        check_field("echo", out_point.echo, want.echo);
        check_field("last_of_scan", {15'd0, out_point.last_of_scan},
                    {15'd0, want.last_of_scan});
      end
      points_checked++;
    end
  end

  // long output hold-off once points start to flow, so the input backs up
  initial begin : output_hold
    wait (hold_req);
    while (exp_points.size() == 0) @(posedge clk);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lidar_hex_scan_frame_parser_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  int send_plan[NUM_PHASES] = '{28, 28, 67, 67, 0, 0};
  int recv_plan[NUM_PHASES] = '{67, 67, 28, 28, 0, 0};
  bit echo_plan[NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  initial begin : stimulus
    int r;
    in_byte.valid   = 1'b0;
    in_byte.rx_byte = 8'h00;
    out_point.ready = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    rst_n           = 1'b0;
    predict_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed frames with echo on
    write_echo(1'b1);
    send_idle_pct = send_plan[0];
    recv_idle_pct = recv_plan[0];
    nib_bad_pct   = 0;
    // stray bytes while hunting
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(lhsfp_pkg::ETX_CHAR);
    // skipped frame with a start byte inside the skipped span
    put_byte(lhsfp_pkg::STX_CHAR);
    put_word(16'h0000);
    put_word(16'h0000);
    put_word(16'h0000);
    put_byte(lhsfp_pkg::STX_CHAR);
    put_byte(8'h41);
    put_byte(lhsfp_pkg::ETX_CHAR);
    // data frame: short length forces a splice, first sector empty, angle wraps
    put_header(16'd12);
    put_fw(16'hFFFF, 1'b1);
    nib_bad_pct = 100;
    put_fw(16'h0000, 1'b1);
    nib_bad_pct = 0;
    put_fw(16'h0000, 1'b1);
    put_fw(16'hFFF2, 1'b1);
    repeat (3) put_fw(16'($urandom), 1'b1);
    put_sector(16'd0, 16'($urandom), 0, 16'h1234);
    put_sector(16'd1, 16'h12FF, 2, 16'hFFF8);
    put_trailer();
    flush_frame(1'b0);
    nib_bad_pct = 1;

    // random phases over idle patterns and both echo settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      write_echo(echo_plan[p]);
      send_idle_pct = send_plan[p];
      recv_idle_pct = recv_plan[p];
      if (p == 0) hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < BYTES_PER_PHASE) begin
        r = $urandom_range(99);
        put_noise();
        if (r < 10) begin
          put_skip_frame();
          flush_frame(1'b0);
        end else begin
          put_random_frame();
          flush_frame(r < 18);
        end
      end
    end
    wait_quiet();

    $display("covered %0d bytes, %0d points, %0d data frames and %0d continuation splices",
             bytes_sent, points_checked, gen_frames, gen_splices);
    $display("with echo on and off, three idle patterns and one long output hold-off");
    if (mismatches == 0) begin
      $display("** lidar_hex_scan_frame_parser_core: PASSED **");
    end else begin
      $display("** lidar_hex_scan_frame_parser_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lhsfp_pkg.sv
src/lhsfp_ifs.sv
src/lhsfp_parser.sv
src/lidar_hex_scan_frame_parser_core.sv
tb/tb.sv
